/* src/lzss_token_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// LZSS token decoder assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef LZSS_TOKEN_DECODER_TOP_ASSERT_SVH
`define LZSS_TOKEN_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LZD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// LZSS token decoder package
// Beat types, field widths and default sizes shared by the decoder modules.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int MAX_MATCH_DEF     = 64;
    localparam int BYTE_W            = 8;
    localparam int OFFSET_W          = 13;
    localparam int LENGTH_W          = 7;

    // One input beat: a literal or a back-reference token.
    typedef struct packed {
        logic                is_match;
        logic [BYTE_W-1:0]   literal;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } lzd_token_t;

    // One output beat: a decoded byte.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } lzd_result_t;

    // History memory controls.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic rd_blank;   // slot never written since reset, reads as zero
    } lzd_mem_ctl_t;

endpackage

/* src/lzss_token_decoder_top.sv */
// ----------------------------------------------------------------------------
// LZSS token decoder
// Expands LZSS tokens into a byte stream through a history ring in RAM.
//
// Token channel (tok_valid / tok_stall / tok_data): one token per beat.
// A literal emits its byte; a copy emits length bytes (saturated at
// MAX_MATCH) read offset bytes back in history, modulo HISTORY_DEPTH.
// Byte channel (dec_valid / dec_stall / dec_data): one byte per beat,
// last_of_run set on each token's final byte. A zero-length copy emits nothing.
// Steps: a literal is written and emitted; a copy runs the offset
// reduction, then reads history through the RAM's single read port and
// emits one byte per cycle while the receiver does not stall.
// tok_stall is low only between tokens.
// Reset: the write pointer returns to zero and a fill flag marks history as
// unwritten; slots not yet written read as zero, so no clearing pass is run.
// Receiver stall: the output register holds its beat and the copy
// read/emit loop freezes, RAM read data included, until dec_stall drops.
// ----------------------------------------------------------------------------
module lzss_token_decoder_top #(
    parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_MATCH     = lzd_pkg::MAX_MATCH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_valid,
    output logic                 tok_stall,
    input  lzd_pkg::lzd_token_t  tok_data,
    output logic                 dec_valid,
    input  logic                 dec_stall,
    output lzd_pkg::lzd_result_t dec_data
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int DW = $clog2(HISTORY_DEPTH + 1);
    localparam int LW = $clog2(MAX_MATCH + 1);
    localparam logic [AW-1:0]       LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [LENGTH_W-1:0] MAX_LEN   = LENGTH_W'(MAX_MATCH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,   // waiting for a token
        ST_LIT  = 4'b0010,   // literal write
        ST_DIV  = 4'b0100,   // offset reduction
        ST_COPY = 4'b1000    // read/emit loop
    } state_t;

    // Sequencer state
    state_t            state_reg,    state_next;
    logic [AW-1:0]     wp_reg,       wp_next;
    logic              wrapped_reg,  wrapped_next;
    logic [AW-1:0]     rd_ptr_reg,   rd_ptr_next;
    logic [LW-1:0]     remain_reg,   remain_next;
    logic              s1_valid_reg, s1_valid_next;   // read in flight
    logic              s1_last_reg,  s1_last_next;
    logic [BYTE_W-1:0] lit_reg,      lit_next;

    // Output register
    logic              out_valid_reg;
    lzd_result_t       out_data_reg;

    logic              tok_accept;
    logic              adv;
    logic [LW-1:0]     len_sat;
    logic [AW-1:0]     wp_inc;
    logic [AW-1:0]     rd_inc;
    logic [DW:0]       diff;
    logic [AW-1:0]     rd_start;
    logic              dist_valid;
    logic [DW-1:0]     copy_dist;
    lzd_mem_ctl_t      mem_ctl;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] rdata;
    logic              res_last;

    assign tok_stall  = (state_reg != ST_IDLE);
    assign tok_accept = tok_valid && !tok_stall;
    // Pipeline may move when the output register is free or draining
    assign adv        = !out_valid_reg || !dec_stall;

    assign len_sat = (tok_data.length > MAX_LEN) ? LW'(MAX_MATCH) : LW'(tok_data.length);
    assign wp_inc  = (wp_reg == LAST_SLOT) ? '0 : wp_reg + AW'(1);
    assign rd_inc  = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);

    // First read slot: wp - distance around the ring
    assign diff     = (DW+1)'(wp_reg) - (DW+1)'(copy_dist);
    assign rd_start = diff[DW] ? AW'(diff + (DW+1)'(HISTORY_DEPTH)) : AW'(diff);

    // Only copies that emit bytes start a reduction
    lzd_dist_unit #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (tok_accept && tok_data.is_match && (len_sat != '0)),
        .offset     (tok_data.offset),
        .dist_valid (dist_valid),
        .copy_dist  (copy_dist)
    );

    lzd_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .raddr (rd_ptr_reg),
        .waddr (wp_reg),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        wrapped_next  = wrapped_reg;
        rd_ptr_next   = rd_ptr_reg;
        remain_next   = remain_reg;
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        lit_next      = lit_reg;
        mem_ctl       = '0;
        wdata         = lit_reg;
        res_last      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tok_accept)
                begin
                    lit_next    = tok_data.literal;
                    remain_next = len_sat;
                    if (!tok_data.is_match)
                    begin
                        state_next = ST_LIT;
                    end
                    else if (len_sat != '0)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_LIT:
            begin
                if (adv)
                begin
                    mem_ctl.wr_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (dist_valid)
                begin
                    rd_ptr_next   = rd_start;
                    s1_valid_next = 1'b0;
                    state_next    = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (adv)
                begin
                    // Retire the byte from the previously issued read
                    if (s1_valid_reg)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        wdata         = rdata;
                        res_last      = s1_last_reg;
                    end
                    // Issue the next read
                    if (remain_reg != '0)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        remain_next   = remain_reg - LW'(1);
                        rd_ptr_next   = rd_inc;
                        s1_valid_next = 1'b1;
                        s1_last_next  = (remain_reg == LW'(1));
                    end
                    else
                    begin
                        s1_valid_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_ctl.wr_en)
        begin
            wp_next = wp_inc;
            if (wp_reg == LAST_SLOT)
            begin
                wrapped_next = 1'b1;
            end
        end
        // Written slots: all once wrapped, else those below the write pointer.
        // Uses post-write pointer; a same-slot write is forwarded by the RAM.
        mem_ctl.rd_blank = !(wrapped_next || (rd_ptr_reg < wp_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            remain_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            wrapped_reg  <= wrapped_next;
            remain_reg   <= remain_next;
            s1_valid_reg <= s1_valid_next;
            s1_last_reg  <= s1_last_next;
            if (mem_ctl.wr_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!dec_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        lit_reg    <= lit_next;
        if (mem_ctl.wr_en)
        begin
            out_data_reg.out_byte    <= wdata;
            out_data_reg.last_of_run <= res_last;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec_data  = out_data_reg;

`include "lzss_token_decoder_top_assert.svh"

    // A token's final byte always returns the sequencer to idle
    `LZD_ASSERT_NEXT(a_last_ends_token, mem_ctl.wr_en && res_last, state_reg == ST_IDLE, "last byte did not end token")
    // Distance result arrives only while the sequencer waits for it
    `LZD_ASSERT_NOW(a_dist_in_div, dist_valid, state_reg == ST_DIV, "distance outside wait state")
    // Reads are in flight only during a copy
    `LZD_ASSERT_NOW(a_read_in_copy, s1_valid_reg, state_reg == ST_COPY, "read in flight outside copy")
    // Reduced distance lies in 1..HISTORY_DEPTH
    `LZD_ASSERT_NOW(a_dist_range, dist_valid, (copy_dist != '0) && (copy_dist <= DW'(HISTORY_DEPTH)), "distance out of range")

endmodule

/* src/lzd_dist_unit.sv */
// ----------------------------------------------------------------------------
// LZSS copy distance unit
// Two-stage offset modulo history depth; zero remainder maps to full depth.
// ----------------------------------------------------------------------------
module lzd_dist_unit #(
    parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [lzd_pkg::OFFSET_W-1:0]       offset,
    output logic                               dist_valid,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0] copy_dist
);
    import lzd_pkg::*;

    localparam int DW = $clog2(HISTORY_DEPTH + 1);
    // Reciprocal exact for every 13-bit dividend
    localparam int K = OFFSET_W + $clog2(HISTORY_DEPTH);
    localparam longint unsigned RECIP_L =
        ((64'd1 << K) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH);
    localparam int RW = $clog2(RECIP_L + 1);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam logic [DW-1:0] DEPTH_C = DW'(HISTORY_DEPTH);
    localparam int P1W = OFFSET_W + RW;
    localparam int P2W = OFFSET_W + DW;

    logic                v1_reg;
    logic                v2_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [OFFSET_W-1:0] quo_reg;
    logic [DW-1:0]       dist_reg;

    logic [P1W-1:0]      prod1;
    logic [OFFSET_W-1:0] quo_next;
    logic [P2W-1:0]      prod2;
    logic [OFFSET_W-1:0] rem;
    logic [DW-1:0]       dist_next;

    always_comb
    begin
        prod1     = P1W'(offset) * P1W'(RECIP);
        quo_next  = OFFSET_W'(prod1 >> K);
        prod2     = P2W'(quo_reg) * P2W'(DEPTH_C);
        rem       = OFFSET_W'(P2W'(off_reg) - prod2);
        dist_next = (rem == '0) ? DEPTH_C : DW'(rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            off_reg <= offset;
            quo_reg <= quo_next;
        end
        if (v1_reg)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_valid = v2_reg;
    assign copy_dist  = dist_reg;

endmodule

/* src/lzd_hist_mem.sv */
// ----------------------------------------------------------------------------
// LZSS history memory
// Single-port-write, single-read synchronous RAM, read-first, with
// same-slot write forwarding and zero substitution for unwritten slots.
// ----------------------------------------------------------------------------
module lzd_hist_mem #(
    parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lzd_pkg::lzd_mem_ctl_t            ctl,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
    input  logic [lzd_pkg::BYTE_W-1:0]       wdata,
    output logic [lzd_pkg::BYTE_W-1:0]       rdata
);
    import lzd_pkg::*;

    logic [BYTE_W-1:0] mem [HISTORY_DEPTH];
    logic [BYTE_W-1:0] q_reg;
    logic [BYTE_W-1:0] fwd_reg;
    logic              hit_reg;
    logic              blank_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            q_reg   <= mem[raddr];
            fwd_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            blank_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            hit_reg   <= ctl.wr_en && (raddr == waddr);
            blank_reg <= ctl.rd_blank;
        end
    end

    // Outputs hold while rd_en is low, so a stalled read stays put.
    assign rdata = hit_reg ? fwd_reg : (blank_reg ? '0 : q_reg);

endmodule
